// ===== rtl/upd_pkg.sv =====
`default_nettype none

package upd_pkg;

   // Character codes
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_LA      = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h66;
   localparam logic [7:0] CH_UA      = 8'h41;
   localparam logic [7:0] CH_UF      = 8'h46;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   // Reported count saturates here
   localparam logic [15:0] REPORT_MAX = 16'hFFFF;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PCT  = 2'd1,
      PH_HI   = 2'd2,
      PH_DROP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_TRUNC = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   // One classified input beat
   typedef struct packed {
      logic [7:0] data;      // raw byte; plus->space when enabled
      logic       is_pct;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       last;
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/upd_front.sv =====
`default_nettype none

module upd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output upd_pkg::token_type     token
);

   logic plus_space_ff;
   logic plus_space_in;

   assign csr_ready = 1'b1;

   // Mode register
   always_comb begin
      plus_space_in = plus_space_ff;
      if (csr_valid) begin
         plus_space_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_space_ff <= 1'b0;
      end else begin
         plus_space_ff <= plus_space_in;
      end
   end

   // Classify the byte
   always_comb begin
      token.data    = in_byte;
      token.is_pct  = (in_byte == upd_pkg::CH_PERCENT);
      token.is_hex  = 1'b0;
      token.hex_val = 4'd0;
      token.last    = in_last;
      if (plus_space_ff && in_byte == upd_pkg::CH_PLUS) begin
         token.data = upd_pkg::CH_SPACE;
      end
      if (in_byte >= upd_pkg::CH_0 && in_byte <= upd_pkg::CH_9) begin
         token.is_hex  = 1'b1;
         token.hex_val = 4'(in_byte - upd_pkg::CH_0);
      end else if (in_byte >= upd_pkg::CH_LA && in_byte <= upd_pkg::CH_LF) begin
         token.is_hex  = 1'b1;
         token.hex_val = 4'(in_byte - upd_pkg::CH_LA + upd_pkg::HEX_TEN);
      end else if (in_byte >= upd_pkg::CH_UA && in_byte <= upd_pkg::CH_UF) begin
         token.is_hex  = 1'b1;
         token.hex_val = 4'(in_byte - upd_pkg::CH_UA + upd_pkg::HEX_TEN);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/upd_queue.sv =====
`default_nettype none

module upd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire upd_pkg::token_type  push_data,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output upd_pkg::token_type       pop_data
);

   upd_pkg::token_type                  slot_ff [upd_pkg::QUEUE_DEPTH];
   logic [upd_pkg::QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [upd_pkg::QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [upd_pkg::QCNT_BITS-1:0]       count_ff, count_in;
   logic                                push;
   logic                                pop;

   assign push_ready = (count_ff != upd_pkg::QCNT_BITS'(upd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == upd_pkg::QPTR_BITS'(upd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == upd_pkg::QPTR_BITS'(upd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/upd_back.sv =====
`default_nettype none

module upd_back #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                tok_valid,
   output logic                     tok_ready,
   input  wire upd_pkg::token_type  tok,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               out_byte,
   output upd_pkg::status_type      out_status,
   output logic                     out_final,
   output logic [15:0]              out_count
);

   upd_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             nibble_ff, nibble_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             byte_ff, byte_in;
   upd_pkg::status_type    status_ff, status_in;
   logic                   final_ff, final_in;
   logic [15:0]            report_ff, report_in;

   logic                   take;
   logic                   emit;
   logic                   emit_data;
   logic [COUNT_BITS-1:0]  count_inc;
   logic [COUNT_BITS-1:0]  count_rep;

   // Pop when the output register is empty or being drained
   assign tok_ready = !valid_ff || out_ready;
   assign take      = tok_valid && tok_ready;
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign count_rep = emit_data ? count_inc : count_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            upd_pkg::PH_IDLE: begin
               if (tok.is_pct && !tok.last) begin
                  phase_in = upd_pkg::PH_PCT;
               end
            end
            upd_pkg::PH_PCT: begin
               if (tok.last) begin
                  phase_in = upd_pkg::PH_IDLE;
               end else if (!tok.is_hex) begin
                  phase_in = upd_pkg::PH_DROP;
               end else begin
                  phase_in = upd_pkg::PH_HI;
               end
            end
            upd_pkg::PH_HI: begin
               if (!tok.is_hex && !tok.last) begin
                  phase_in = upd_pkg::PH_DROP;
               end else begin
                  phase_in = upd_pkg::PH_IDLE;
               end
            end
            upd_pkg::PH_DROP: begin
               if (tok.last) begin
                  phase_in = upd_pkg::PH_IDLE;
               end
            end
            default: phase_in = upd_pkg::PH_IDLE;
         endcase
      end
   end

   // Result selection, nibble and count
   always_comb begin
      emit      = 1'b0;
      emit_data = 1'b0;
      byte_in   = 8'd0;
      status_in = upd_pkg::ST_DATA;
      final_in  = tok.last;
      nibble_in = nibble_ff;
      unique case (phase_ff)
         upd_pkg::PH_IDLE: begin
            if (tok.is_pct) begin
               emit      = tok.last;
               status_in = upd_pkg::ST_TRUNC;
            end else begin
               emit      = 1'b1;
               emit_data = 1'b1;
               byte_in   = tok.data;
            end
         end
         upd_pkg::PH_PCT: begin
            if (tok.last) begin
               emit      = 1'b1;
               status_in = upd_pkg::ST_TRUNC;
            end else if (!tok.is_hex) begin
               emit      = 1'b1;
               status_in = upd_pkg::ST_BAD;
               final_in  = 1'b1;
            end else begin
               nibble_in = tok.hex_val;
            end
         end
         upd_pkg::PH_HI: begin
            emit = 1'b1;
            if (!tok.is_hex) begin
               status_in = upd_pkg::ST_BAD;
               final_in  = 1'b1;
            end else begin
               emit_data = 1'b1;
               byte_in   = {nibble_ff, tok.hex_val};
            end
         end
         upd_pkg::PH_DROP: begin
            emit = 1'b0;
         end
         default: emit = 1'b0;
      endcase

      report_in = (count_rep > COUNT_BITS'(upd_pkg::REPORT_MAX))
                  ? upd_pkg::REPORT_MAX : 16'(count_rep);

      count_in = count_ff;
      if (take) begin
         if ((emit && final_in) || (phase_ff == upd_pkg::PH_DROP && tok.last)) begin
            count_in = '0;
         end else if (emit_data) begin
            count_in = count_inc;
         end
      end

      valid_in = valid_ff && !out_ready;
      if (take && emit) begin
         valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= upd_pkg::PH_IDLE;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
         nibble_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         if (take) begin
            nibble_ff <= nibble_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (take && emit) begin
         byte_ff   <= byte_in;
         status_ff <= status_in;
         final_ff  <= final_in;
         report_ff <= report_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_status = status_ff;
   assign out_final  = final_ff;
   assign out_count  = report_ff;

endmodule

`default_nettype wire

// ===== rtl/url_percent_decoder.sv =====
// An accepted byte is first written to the queue and then popped into the
// back-end result register, which drives rsp_tvalid; rsp_tready can stall it.
// Throughput: one byte per cycle unless rsp_tready stalls the result register.
// A two-entry queue sits between the classifier and the decoder.
// Reset (synchronous, active high) empties the queue and the result register,
// returns to the idle phase, zeroes the byte count and clears plus-as-space.
`default_nettype none

module url_percent_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] in_byte
   input  wire logic         req_tlast,   // end_of_string
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,   // [7:0] out_byte, [23:8] bytes_written
   output logic [1:0]        rsp_tuser,   // [1:0] status
   output logic              rsp_tlast,   // final_result
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_data     // plus_means_space
);

   upd_pkg::token_type   fr_token;
   upd_pkg::token_type   q_token;
   logic                 q_valid;
   logic                 q_ready;
   logic [7:0]           out_byte;
   upd_pkg::status_type  out_status;
   logic [15:0]          out_count;

   upd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .token     (fr_token)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  (fr_token),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_token)
   );

   upd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (q_valid),
      .tok_ready  (q_ready),
      .tok        (q_token),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_status (out_status),
      .out_final  (rsp_tlast),
      .out_count  (out_count)
   );

   assign rsp_tdata = {out_count, out_byte};
   assign rsp_tuser = out_status;

   // Error beats always close the string
   a_err_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != upd_pkg::ST_DATA) |-> rsp_tlast)
      else $error("error beat without final flag");

   // Error beats carry a zero byte
   a_err_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != upd_pkg::ST_DATA) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("error beat with nonzero byte");

   // Only the three defined status codes are produced
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == upd_pkg::ST_DATA || rsp_tuser == upd_pkg::ST_TRUNC ||
                      rsp_tuser == upd_pkg::ST_BAD))
      else $error("undefined status code");

endmodule

`default_nettype wire
